// ----- sv/mahsp_pkg.sv -----
package mahsp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  version_code;
      logic [1:0]  layer_number;
      logic        crc_present;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic        padding;
      logic [1:0]  channel_mode;
      logic [1:0]  stereo_ext;
      logic [2:0]  flag_bits;
      logic [1:0]  emphasis;
      logic [11:0] frame_length;
      logic [10:0] samples_per_frame;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

   localparam logic REG_FIRST_ONLY = 1'b0;

   localparam logic [31:0] SYNC_MASK  = 32'hffe0_0000;
   localparam logic [31:0] TOP16_MASK = 32'hffff_0000;
   localparam logic [31:0] SYNC_FFFE  = 32'hfffe_0000;

   localparam logic [1:0] VER_RESERVED   = 2'd1;
   localparam logic [1:0] LAYER_RESERVED = 2'd0;
   localparam logic [1:0] LAYER_BITS_L1  = 2'd3;
   localparam logic [3:0] BRI_FREE       = 4'd0;
   localparam logic [3:0] BRI_BAD        = 4'd15;
   localparam logic [1:0] SRI_BAD        = 2'd3;

   localparam logic [17:0] COEF_L1    = 18'd48000;
   localparam logic [17:0] COEF_L23   = 18'd144000;
   localparam logic [10:0] SPF_L1     = 11'd384;
   localparam logic [10:0] SPF_L23    = 11'd1152;
   localparam int          QUOT_BITS  = 12;

   localparam logic [8:0] BR_V2_L1 [0:15] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [8:0] BR_V2_L23 [0:15] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
      9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
   localparam logic [8:0] BR_V1_L1 [0:15] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [8:0] BR_V1_L2 [0:15] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [8:0] BR_V1_L3 [0:15] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
      9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};

   function automatic logic window_ok(input logic [31:0] h);
      logic ok;
      ok = 1'b1;
      if ((h & SYNC_MASK) != SYNC_MASK) ok = 1'b0;
      if (h[18:17] == LAYER_RESERVED) ok = 1'b0;
      if (h[15:12] == BRI_FREE || h[15:12] == BRI_BAD) ok = 1'b0;
      if (h[11:10] == SRI_BAD) ok = 1'b0;
      // layer 1 in version-1 streams must carry a crc
      if (h[19] && h[18:17] == LAYER_BITS_L1 && h[16]) ok = 1'b0;
      if ((h & TOP16_MASK) == SYNC_FFFE) ok = 1'b0;
      if (h[20:19] == VER_RESERVED) ok = 1'b0;
      return ok;
   endfunction

   function automatic logic [8:0] bitrate_lookup(input logic [31:0] h);
      logic [8:0] br;
      case ({h[19], h[18:17]}) inside
         3'b011:  br = BR_V2_L1[h[15:12]];
         3'b111:  br = BR_V1_L1[h[15:12]];
         3'b110:  br = BR_V1_L2[h[15:12]];
         3'b101:  br = BR_V1_L3[h[15:12]];
         3'b010, 3'b001: br = BR_V2_L23[h[15:12]];
         default: br = 9'd0;
      endcase
      return br;
   endfunction

   function automatic logic [15:0] sample_rate_lookup(input logic [31:0] h);
      logic [15:0] sr;
      case ({h[20:19], h[11:10]})
         4'b0000: sr = 16'd11025;
         4'b0001: sr = 16'd12000;
         4'b0010: sr = 16'd8000;
         4'b1000: sr = 16'd22050;
         4'b1001: sr = 16'd24000;
         4'b1010: sr = 16'd16000;
         4'b1100: sr = 16'd44100;
         4'b1101: sr = 16'd48000;
         4'b1110: sr = 16'd32000;
         default: sr = 16'd0;
      endcase
      return sr;
   endfunction

endpackage

// ----- sv/mahsp_front.sv -----
module mahsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mahsp_pkg::req_type req_data,
   input  logic             first_only,
   input  logic             queue_full,
   output logic             hit_valid,
   output logic [31:0]      hit_window
);
   import mahsp_pkg::*;

   logic [23:0] window_ff, window_in;
   logic        found_ff, found_in;
   logic [23:0] window_base;
   logic        found_base;
   logic [31:0] h;
   logic        accept;
   logic        hit;

   assign accept = push && !queue_full;

   always_comb begin
      // a new file clears the window and the found flag before the byte lands
      window_base = req_data.new_file ? 24'd0 : window_ff;
      found_base  = req_data.new_file ? 1'b0 : found_ff;
      h           = {window_base, req_data.data_byte};
      hit         = window_ok(h) && !(first_only && found_base);
      window_in   = window_ff;
      found_in    = found_ff;
      if (accept) begin
         window_in = h[23:0];
         found_in  = found_base | hit;
      end
   end

   assign hit_valid  = accept && hit;
   assign hit_window = h;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 24'd0;
         found_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         found_ff  <= found_in;
      end
   end

endmodule

// ----- sv/mahsp_queue.sv -----
module mahsp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [31:0]            wr_data,
   input  logic                   rd_en,
   output logic [31:0]            rd_data,
   output mahsp_pkg::queue_stat_type stat
);
   import mahsp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0]   mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr = wr_en && !stat.full;
   assign do_rd = rd_en && !stat.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd) rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ----- sv/mahsp_back.sv -----
module mahsp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mahsp_pkg::queue_stat_type q_stat,
   input  logic [31:0]               q_data,
   output logic                      q_pop,
   input  logic                      pop,
   output logic                      empty,
   output mahsp_pkg::rsp_type        rsp_data
);
   import mahsp_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [8:0]  br_ff, br_in;
   logic [15:0] sr_ff, sr_in;
   logic [25:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [3:0]  bit_ff, bit_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        is_l1;
   logic [26:0] divisor;
   logic        ge;
   logic [26:0] product;
   logic [11:0] pad_add;
   logic        load;

   assign is_l1   = (hdr_ff[18:17] == LAYER_BITS_L1);
   assign product = (is_l1 ? 27'(COEF_L1) : 27'(COEF_L23)) * 27'(br_ff);
   assign divisor = 27'(sr_ff) << bit_ff;
   assign ge      = ({1'b0, rem_ff} >= divisor);
   assign pad_add = is_l1 ? {9'd0, hdr_ff[9], 2'b00} : {11'd0, hdr_ff[9]};

   always_comb begin
      state_in = state_ff;
      hdr_in   = hdr_ff;
      br_in    = br_ff;
      sr_in    = sr_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      bit_in   = bit_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               hdr_in   = q_data;
               br_in    = bitrate_lookup(q_data);
               sr_in    = sample_rate_lookup(q_data);
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            rem_in   = product[25:0];
            quot_in  = '0;
            bit_in   = 4'(QUOT_BITS - 1);
            state_in = BK_DIV;
         end
         BK_DIV: begin
            // restoring divide, one quotient bit per cycle from the top
            if (ge) rem_in = rem_ff - divisor[25:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], ge};
            if (bit_ff == 4'd0) state_in = BK_DONE;
            else bit_in = bit_ff - 1'b1;
         end
         BK_DONE: begin
            if (!out_valid_ff || pop) begin
               load     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      out_in                   = out_ff;
      if (load) begin
         out_in.version_code      = hdr_ff[20:19];
         out_in.layer_number      = 2'(3'd4 - {1'b0, hdr_ff[18:17]});
         out_in.crc_present       = !hdr_ff[16];
         out_in.bitrate_kbps      = br_ff;
         out_in.sample_rate_hz    = sr_ff;
         out_in.padding           = hdr_ff[9];
         out_in.channel_mode      = hdr_ff[7:6];
         out_in.stereo_ext        = hdr_ff[5:4];
         out_in.flag_bits         = {hdr_ff[8], hdr_ff[3], hdr_ff[2]};
         out_in.emphasis          = hdr_ff[1:0];
         out_in.frame_length      = quot_ff + pad_add;
         out_in.samples_per_frame = is_l1 ? SPF_L1 : SPF_L23;
      end
      out_valid_in = load ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      br_ff   <= br_in;
      sr_ff   <= sr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      bit_ff  <= bit_in;
      out_ff  <= out_in;
   end

endmodule

// ----- sv/mpeg_audio_header_sync_parser_top.sv -----
// Byte-stream MPEG audio header finder. Bytes are taken one per cycle (push while full is low);
// every byte offset is checked as the last byte of a 32-bit header, and a hit is decoded into
// its fields, table bitrate and sample rate, frame length and samples per frame. While full is
// low every byte, hit or not, is taken; while it is high every byte waits. Each hit passes
// through the decode side in order: the table lookups, the coefficient-times-bitrate multiply,
// the restoring divider that produces the frame length one quotient bit per cycle, and the load
// of the result register, which waits until that register is free or being popped. Hits wait
// in a QUEUE_DEPTH-entry queue between the byte side and the decode side; full rises only while
// that queue is full. Register first_only (address 0, reset 1) limits reporting to the first
// header of each file.
module mpeg_audio_header_sync_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  mahsp_pkg::req_type  req_data,
   output logic                empty,
   input  logic                pop,
   output mahsp_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import mahsp_pkg::*;

   logic           first_only_ff, first_only_in;
   logic           hit_valid;
   logic [31:0]    hit_window;
   logic [31:0]    q_data;
   logic           q_pop;
   queue_stat_type q_stat;

   assign pready = 1'b1;

   always_comb begin
      first_only_in = first_only_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_FIRST_ONLY)
         first_only_in = pwdata[0];
      prdata = (paddr[2] == REG_FIRST_ONLY) ? {31'd0, first_only_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) first_only_ff <= 1'b1;
      else first_only_ff <= first_only_in;
   end

   assign full = q_stat.full;

   mahsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .first_only (first_only_ff),
      .queue_full (q_stat.full),
      .hit_valid  (hit_valid),
      .hit_window (hit_window)
   );

   mahsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hit_valid),
      .wr_data (hit_window),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .stat    (q_stat)
   );

   mahsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

// ----- sv/mahsp_checker.sv -----
module mahsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input mahsp_pkg::req_type req_data,
   input logic               empty,
   input logic               pop,
   input mahsp_pkg::rsp_type rsp_data,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [2:0]         paddr,
   input logic [31:0]        pwdata,
   input logic [31:0]        prdata,
   input logic               pready
);
   import mahsp_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result pending right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_spf_layer: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_data.layer_number == 2'd1) == (rsp_data.samples_per_frame == SPF_L1)))
      else $error("samples per frame does not match layer");

   a_fields: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.layer_number != 2'd0 && rsp_data.version_code != VER_RESERVED
                  && rsp_data.frame_length >= 12'd32))
      else $error("reported header has reserved fields or short frame");

endmodule

bind mpeg_audio_header_sync_parser_top mahsp_checker u_mahsp_checker (.*);
